FILE: hdl/ljpes_pkg.sv
// Shared types and constants for the Lennard-Jones pair energy accumulator.
`timescale 1ns / 1ps
package ljpes_pkg;

  localparam int SUM_WIDTH   = 48;
  localparam int COUNT_WIDTH = 24;
  // Signed width that holds any pair term before it joins the sum.
  localparam int TERM_W      = 70;
  localparam int SQRT_STEPS  = 16;
  localparam int DIV_STEPS   = 20;

  localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic [15:0] radius_a;
    logic [15:0] radius_b;
    logic [15:0] depth_a;
    logic [15:0] depth_b;
    logic [15:0] distance;
    logic        last_pair;
  } in_word_t;

  typedef struct packed {
    logic signed [SUM_WIDTH-1:0] total_energy;
    logic                        saturated;
    logic [COUNT_WIDTH-1:0]      pairs_added;
  } out_word_t;

  // Classified pair as it travels from the front to the back.
  typedef struct packed {
    logic [16:0] radius_sum;
    logic [31:0] depth_prod;
    logic [15:0] distance;
    logic        last_pair;
    logic        in_cutoff;
  } pair_word_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ITER, ST_CHK, ST_MQ, ST_MR2, ST_MX, ST_MR6, ST_MHL,
    ST_MLL, ST_MM, ST_MDIFF, ST_MLO, ST_MHI, ST_TERM, ST_ACC, ST_FIN
  } back_state_t;

endpackage

FILE: hdl/ljpes_front.sv
// Front end: holds the cutoff register, takes pairs and classifies them.
`timescale 1ns / 1ps
module ljpes_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [15:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ljpes_pkg::in_word_t  in_data,
  output logic                 push,
  input  logic                 push_ready,
  output ljpes_pkg::pair_word_t push_data
);

  logic                  cutoff;
  logic [15:0]           cutoff_distance;
  logic                  stage_valid;
  ljpes_pkg::pair_word_t stage;
  ljpes_pkg::pair_word_t stage_next;

  assign cfg_ready = 1'b1;

  // Cutoff register; zero means every pair is used.
  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff_distance <= '0;
    end else if (cfg_valid) begin
      cutoff_distance <= cfg_data;
    end
  end

  assign cutoff = (cutoff_distance == 16'd0) || (in_data.distance < cutoff_distance);

  // Radius sum and depth product for the incoming word.
  always_comb begin
    stage_next.radius_sum = 17'(in_data.radius_a) + 17'(in_data.radius_b);
    stage_next.depth_prod = 32'(in_data.depth_a) * 32'(in_data.depth_b);
    stage_next.distance   = in_data.distance;
    stage_next.last_pair  = in_data.last_pair;
    stage_next.in_cutoff  = cutoff;
  end

  assign in_ready  = !stage_valid || push_ready;
  assign push      = stage_valid;
  assign push_data = stage;

  // One register stage ahead of the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage <= stage_next;
    end
  end

endmodule

FILE: hdl/ljpes_queue.sv
// Two-entry queue between the front end and the back end.
`timescale 1ns / 1ps
module ljpes_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  push_ready,
  input  ljpes_pkg::pair_word_t push_data,
  output logic                  pop_valid,
  input  logic                  pop,
  output ljpes_pkg::pair_word_t pop_data
);

  ljpes_pkg::pair_word_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

FILE: hdl/ljpes_back.sv
// Back end: square root, ratio division, power chain, term and running sum.
`timescale 1ns / 1ps
module ljpes_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pop_valid,
  output logic                  pop,
  input  ljpes_pkg::pair_word_t pop_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ljpes_pkg::out_word_t  out_data
);

  localparam int SW = ljpes_pkg::SUM_WIDTH;
  localparam int CW = ljpes_pkg::COUNT_WIDTH;
  localparam int TW = ljpes_pkg::TERM_W;
  localparam int SX = TW + 1;

  ljpes_pkg::back_state_t state;
  ljpes_pkg::back_state_t state_next;

  logic [15:0] pair_dist;
  logic        last;
  logic        use_pair;
  logic        huge;
  logic [4:0]  iter_cnt;
  logic [31:0] sq_n;
  logic [31:0] sq_res;
  logic [31:0] sq_bit;
  logic [32:0] sq_try;
  logic [15:0] div_rem;
  logic [19:0] div_sh;
  logic [19:0] div_q;
  logic [16:0] div_try;
  logic [15:0] e;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [23:0] r2;
  logic [39:0] r6;
  logic [63:0] acc;
  logic [40:0] two_r6;
  logic [63:0] m;
  logic        m_neg;
  logic [47:0] plo;
  logic [79:0] p_full;
  logic [80:0] p_ceil;
  logic [67:0] t_pos;
  logic signed [TW-1:0] term;
  logic        term_sat;
  logic signed [SX-1:0] sum_wide;
  logic signed [SW-1:0] energy_sum;
  logic        saturation_seen;
  logic [CW-1:0] pair_counter;
  logic        out_free;
  logic        emit;

  assign e        = sq_res[15:0];
  assign out_free = !out_valid || out_ready;
  assign pop      = (state == ljpes_pkg::ST_IDLE) && pop_valid;
  assign emit     = (state == ljpes_pkg::ST_FIN) && last && out_free;

  // One shared 32 by 32 multiplier; its operands follow the step.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ljpes_pkg::ST_MQ: begin
        mul_a = 32'(div_q);
        mul_b = 32'(div_q);
      end
      ljpes_pkg::ST_MR2: begin
        mul_a = 32'(prod[39:16]);
        mul_b = 32'(prod[39:16]);
      end
      ljpes_pkg::ST_MX: begin
        mul_a = prod[47:16];
        mul_b = 32'(r2);
      end
      ljpes_pkg::ST_MR6: begin
        mul_a = 32'(prod[55:32]);
        mul_b = 32'(prod[55:32]);
      end
      ljpes_pkg::ST_MHL: begin
        mul_a = 32'(r6[39:16]);
        mul_b = 32'(r6[15:0]);
      end
      ljpes_pkg::ST_MLL: begin
        mul_a = 32'(r6[15:0]);
        mul_b = 32'(r6[15:0]);
      end
      ljpes_pkg::ST_MLO: begin
        mul_a = m[31:0];
        mul_b = 32'(e);
      end
      ljpes_pkg::ST_MHI: begin
        mul_a = m[63:32];
        mul_b = 32'(e);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= 64'(mul_a) * 64'(mul_b);
  end

  // Iteration steps for the square root and the restoring division.
  assign sq_try  = 33'(sq_res) + 33'(sq_bit);
  assign div_try = {div_rem, div_sh[19]};
  assign two_r6  = {r6, 1'b0};

  // Final term from the two partial products of magnitude times depth.
  always_comb begin
    p_full = {prod[47:0], 32'b0} + {32'b0, plo};
    p_ceil = 81'(p_full) + 81'd4095;
    t_pos  = p_full[79:12];
  end

  assign sum_wide = SX'(energy_sum) + SX'(term);

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ljpes_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ljpes_pkg::ST_IDLE: begin
        if (pop_valid) begin
          state_next = pop_data.in_cutoff ? ljpes_pkg::ST_ITER : ljpes_pkg::ST_FIN;
        end
      end
      ljpes_pkg::ST_ITER: begin
        if (iter_cnt == 5'(ljpes_pkg::DIV_STEPS - 1)) begin
          state_next = ljpes_pkg::ST_CHK;
        end
      end
      ljpes_pkg::ST_CHK: begin
        if (e == 16'd0 || huge) begin
          state_next = ljpes_pkg::ST_ACC;
        end else begin
          state_next = ljpes_pkg::ST_MQ;
        end
      end
      ljpes_pkg::ST_MQ:    state_next = ljpes_pkg::ST_MR2;
      ljpes_pkg::ST_MR2:   state_next = ljpes_pkg::ST_MX;
      ljpes_pkg::ST_MX:    state_next = ljpes_pkg::ST_MR6;
      ljpes_pkg::ST_MR6:   state_next = ljpes_pkg::ST_MHL;
      ljpes_pkg::ST_MHL:   state_next = ljpes_pkg::ST_MLL;
      ljpes_pkg::ST_MLL:   state_next = ljpes_pkg::ST_MM;
      ljpes_pkg::ST_MM:    state_next = ljpes_pkg::ST_MDIFF;
      ljpes_pkg::ST_MDIFF: state_next = ljpes_pkg::ST_MLO;
      ljpes_pkg::ST_MLO:   state_next = ljpes_pkg::ST_MHI;
      ljpes_pkg::ST_MHI:   state_next = ljpes_pkg::ST_TERM;
      ljpes_pkg::ST_TERM:  state_next = ljpes_pkg::ST_ACC;
      ljpes_pkg::ST_ACC:   state_next = ljpes_pkg::ST_FIN;
      ljpes_pkg::ST_FIN: begin
        if (!last || out_free) begin
          state_next = ljpes_pkg::ST_IDLE;
        end
      end
      default: state_next = ljpes_pkg::ST_IDLE;
    endcase
  end

  // Per-pair datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      ljpes_pkg::ST_IDLE: begin
        pair_dist <= pop_data.distance;
        last      <= pop_data.last_pair;
        use_pair  <= pop_data.in_cutoff;
        huge      <= 20'(pop_data.radius_sum) >= {pop_data.distance, 4'b0};
        iter_cnt  <= '0;
        sq_n      <= pop_data.depth_prod;
        sq_res    <= '0;
        sq_bit    <= 32'h4000_0000;
        div_rem   <= 16'(pop_data.radius_sum[16:4]);
        div_sh    <= {pop_data.radius_sum[3:0], 16'b0};
        div_q     <= '0;
      end
      ljpes_pkg::ST_ITER: begin
        iter_cnt <= iter_cnt + 5'd1;
        if (iter_cnt < 5'(ljpes_pkg::SQRT_STEPS)) begin
          if (33'(sq_n) >= sq_try) begin
            sq_n   <= sq_n - sq_try[31:0];
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
        end
        div_sh <= {div_sh[18:0], 1'b0};
        if (div_try >= {1'b0, pair_dist}) begin
          div_rem <= 16'(div_try - {1'b0, pair_dist});
          div_q   <= {div_q[18:0], 1'b1};
        end else begin
          div_rem <= div_try[15:0];
          div_q   <= {div_q[18:0], 1'b0};
        end
      end
      ljpes_pkg::ST_CHK: begin
        if (e == 16'd0) begin
          term     <= '0;
          term_sat <= 1'b0;
        end else begin
          term     <= TW'(ljpes_pkg::SUM_MAX);
          term_sat <= 1'b1;
        end
      end
      ljpes_pkg::ST_MR2: r2 <= prod[39:16];
      ljpes_pkg::ST_MR6: r6 <= prod[55:16];
      ljpes_pkg::ST_MHL: acc <= {prod[47:0], 16'b0};
      ljpes_pkg::ST_MLL: acc <= acc + {prod[62:0], 1'b0};
      ljpes_pkg::ST_MM:  acc <= acc + 64'(prod[63:16]);
      ljpes_pkg::ST_MDIFF: begin
        if (acc >= 64'(two_r6)) begin
          m     <= acc - 64'(two_r6);
          m_neg <= 1'b0;
        end else begin
          m     <= 64'(two_r6) - acc;
          m_neg <= 1'b1;
        end
      end
      ljpes_pkg::ST_MHI: plo <= prod[47:0];
      ljpes_pkg::ST_TERM: begin
        if (m_neg) begin
          term     <= -$signed({1'b0, p_ceil[80:12]});
          term_sat <= 1'b0;
        end else if (t_pos > 68'(ljpes_pkg::SUM_MAX)) begin
          term     <= TW'(ljpes_pkg::SUM_MAX);
          term_sat <= 1'b1;
        end else begin
          term     <= $signed({2'b0, t_pos});
          term_sat <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Running sum, saturation flag and pair count.
  always_ff @(posedge clk) begin
    if (rst) begin
      energy_sum      <= '0;
      saturation_seen <= 1'b0;
      pair_counter    <= '0;
    end else if (state == ljpes_pkg::ST_ACC) begin
      if (sum_wide > SX'(ljpes_pkg::SUM_MAX)) begin
        energy_sum      <= ljpes_pkg::SUM_MAX;
        saturation_seen <= 1'b1;
      end else if (sum_wide < SX'(ljpes_pkg::SUM_MIN)) begin
        energy_sum      <= ljpes_pkg::SUM_MIN;
        saturation_seen <= 1'b1;
      end else begin
        energy_sum <= sum_wide[SW-1:0];
        if (term_sat) begin
          saturation_seen <= 1'b1;
        end
      end
      if (pair_counter != '1) begin
        pair_counter <= pair_counter + CW'(1);
      end
    end else if (emit) begin
      energy_sum      <= '0;
      saturation_seen <= 1'b0;
      pair_counter    <= '0;
    end
  end

  // Output register, so the sum of the next set can go on while a word waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data.total_energy <= energy_sum;
      out_data.saturated    <= saturation_seen;
      out_data.pairs_added  <= pair_counter;
    end
  end

  // A pair is only taken from the queue while the sequencer is idle.
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> state == ljpes_pkg::ST_IDLE)
    else $error("pair taken while the back end is busy");

  // Emitting a word returns the accumulator to its cleared state.
  a_clear: assert property (@(posedge clk) disable iff (rst)
    emit |=> (energy_sum == '0) && !saturation_seen && (pair_counter == '0))
    else $error("accumulator not cleared after emit");

  // A pair outside the cutoff never reaches the arithmetic steps.
  a_skip: assert property (@(posedge clk) disable iff (rst)
    (state == ljpes_pkg::ST_ITER) |-> use_pair)
    else $error("pair outside the cutoff entered the arithmetic");

  // A word is never loaded over one the receiver has not taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    emit |-> (!out_valid || out_ready))
    else $error("output word overwritten");

endmodule

FILE: hdl/lennard_jones_pair_energy_sum.sv
// Top level of the Lennard-Jones 12-6 pair energy accumulator.
//
// Usage: pairs arrive on in_valid/in_ready/in_data, one word per pair. A
// pair whose distance is below cutoff_distance (or any pair when the cutoff
// is zero) adds E*((R/d)^12 - 2*(R/d)^6) to a saturating Q31.16 sum. The
// pair with last_pair set closes the set: one word with the total, the
// saturation flag and the pair count leaves on out_valid/out_ready/out_data
// and the sum, flag and count return to zero.
// The cutoff is written through cfg_valid/cfg_data; cfg_ready is always high.
// A pair inside the cutoff holds the back end until it is done, through
// the 20-step iterative ratio division (the square root runs beside it)
// and eleven steps around the one shared multiplier; with a zero depth
// or a huge ratio it skips the multiplier steps. A pair outside the cutoff
// skips the arithmetic. A front register and a two-entry queue take pairs
// meanwhile. The result word is registered once its last pair is done.
// Reset (rst, synchronous) clears the cutoff, the sum, the front register and the queue.
// While the receiver stalls, the result word holds; the back end waits on
// the next last pair only, and then the queue and front fill and in_ready
// drops.
`timescale 1ns / 1ps
module lennard_jones_pair_energy_sum (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [15:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ljpes_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ljpes_pkg::out_word_t out_data
);

  logic                  push;
  logic                  push_ready;
  ljpes_pkg::pair_word_t push_data;
  logic                  pop_valid;
  logic                  pop;
  ljpes_pkg::pair_word_t pop_data;

  ljpes_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push       (push),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  ljpes_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_data   (pop_data)
  );

  ljpes_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: sim/lennard_jones_pair_energy_sum_checker.sv
// Checker for the pair energy accumulator: predicts each result word and compares it.
`timescale 1ns / 1ps
module lennard_jones_pair_energy_sum_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [15:0]          cfg_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  ljpes_pkg::in_word_t  in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  ljpes_pkg::out_word_t out_data,
  output int                   fail_count,
  output int                   pending
);

  localparam longint TERM_MAX = (64'sd1 <<< (ljpes_pkg::SUM_WIDTH - 1)) - 1;
  localparam longint TERM_MIN = -TERM_MAX - 1;
  localparam logic [ljpes_pkg::COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // Predicted copy of the block's state and its cutoff register.
  logic [15:0]                       cutoff_q;
  longint                            run_sum;
  logic                              run_sat;
  logic [ljpes_pkg::COUNT_WIDTH-1:0] run_count;
  ljpes_pkg::out_word_t              totals_due[$];

  // Integer square root, one result bit at a time.
  function automatic logic [63:0] root_floor(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] t;
    res = 0;
    for (int i = 15; i >= 0; i--) begin
      t = res | (64'd1 << i);
      if (t * t <= n) res = t;
    end
    return res;
  endfunction

  // Energy of one pair in Q.16, clamped to the sum range.
  function automatic longint lj_term(input logic [63:0] r, input logic [63:0] e,
                                     input logic [63:0] d, output logic sat);
    logic [63:0] tmax, q, r2, r6, r12, h, l, m, a, b;
    tmax = TERM_MAX;
    sat = 1'b0;
    if (e == 0) return 0;
    if (d == 0) begin
      sat = 1'b1;
      return TERM_MAX;
    end
    q = (r << 16) / d;
    if (q >= (64'd16 << 16)) begin
      sat = 1'b1;
      return TERM_MAX;
    end
    r2 = (q * q) >> 16;
    r6 = (((r2 * r2) >> 16) * r2) >> 16;
    h = r6 >> 16;
    l = r6 & 64'hFFFF;
    r12 = ((h * h) << 16) + 2 * h * l + ((l * l) >> 16);
    if (r12 >= 2 * r6) begin
      m = r12 - 2 * r6;
      a = m >> 12;
      b = ((m & 64'd4095) * e) >> 12;
      if (a > (tmax - b) / e) begin
        sat = 1'b1;
        return TERM_MAX;
      end
      return longint'(a * e + b);
    end
    m = 2 * r6 - r12;
    return -longint'((m * e + 64'd4095) >> 12);
  endfunction

  assign pending = totals_due.size();

  // Follow configuration and pair words, and queue each predicted total.
  always @(posedge clk) begin
    longint               t;
    logic                 s;
    ljpes_pkg::out_word_t w;
    if (rst) begin
      cutoff_q  <= '0;
      run_sum   = 0;
      run_sat   = 1'b0;
      run_count = '0;
      totals_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) cutoff_q <= cfg_data;
      if (in_valid && in_ready) begin
        if (cutoff_q == 0 || in_data.distance < cutoff_q) begin
          t = lj_term({47'd0, {1'b0, in_data.radius_a} + {1'b0, in_data.radius_b}},
                      root_floor({48'd0, in_data.depth_a} * {48'd0, in_data.depth_b}),
                      {48'd0, in_data.distance}, s);
          if (s) run_sat = 1'b1;
          if (t > 0 && run_sum > TERM_MAX - t) begin
            run_sum = TERM_MAX;
            run_sat = 1'b1;
          end else if (t < 0 && run_sum < TERM_MIN - t) begin
            run_sum = TERM_MIN;
            run_sat = 1'b1;
          end else begin
            run_sum = run_sum + t;
          end
          if (run_count != COUNT_MAX) run_count = run_count + 1'b1;
        end
        if (in_data.last_pair) begin
          w.total_energy = run_sum[ljpes_pkg::SUM_WIDTH-1:0];
          w.saturated    = run_sat;
          w.pairs_added  = run_count;
          totals_due.push_back(w);
          run_sum   = 0;
          run_sat   = 1'b0;
          run_count = '0;
        end
      end
    end
  end

  // Compare each result word with the oldest prediction.
  always @(posedge clk) begin
    ljpes_pkg::out_word_t w;
    if (rst) begin
      fail_count <= 0;
    end else if (out_valid && out_ready) begin
      if (totals_due.size() == 0) begin
        $error("result word with no pair set pending: %h", out_data);
        fail_count <= fail_count + 1;
      end else begin
        w = totals_due.pop_front();
        if (out_data.total_energy !== w.total_energy ||
            out_data.saturated !== w.saturated ||
            out_data.pairs_added !== w.pairs_added) begin
          if (out_data.total_energy !== w.total_energy)
            $error("total_energy: expected %0d, actual %0d",
                   w.total_energy, out_data.total_energy);
          if (out_data.saturated !== w.saturated)
            $error("saturated: expected %0d, actual %0d", w.saturated, out_data.saturated);
          if (out_data.pairs_added !== w.pairs_added)
            $error("pairs_added: expected %0d, actual %0d",
                   w.pairs_added, out_data.pairs_added);
          fail_count <= fail_count + 1;
        end
      end
    end
  end

endmodule

FILE: sim/tb_lennard_jones_pair_energy_sum.sv
// Testbench top: drives pair sets and cutoff settings and reports the verdict.
`timescale 1ns / 1ps
module tb_lennard_jones_pair_energy_sum;

  localparam int CYCLE_LIMIT = 1000000;

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [15:0]          cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  ljpes_pkg::in_word_t  in_data;
  logic                 out_valid;
  logic                 out_ready;
  ljpes_pkg::out_word_t out_data;
  int                   fail_count;
  int                   pending;
  int                   cycles;
  int                   stall_mode;

  lennard_jones_pair_energy_sum dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  lennard_jones_pair_energy_sum_checker chk (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_lennard_jones_pair_energy_sum: FAIL");
      $finish;
    end
  end

  // Receiver stalls: the mode is redrawn at random during the run and sets how often out_ready is high.
  always @(posedge clk) begin
    if (cycles % 64 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(0, 1);
      2: out_ready <= ($urandom_range(0, 7) == 0);
      default: out_ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Present one pair word and hold it until accepted.
  task automatic send_pair(input ljpes_pkg::in_word_t w);
    in_valid <= 1'b1;
    in_data  <= w;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic pause_sender(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Drain all totals, let the back end settle, then write the cutoff.
  task automatic set_cutoff(input logic [15:0] value);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic ljpes_pkg::in_word_t pair_of(input logic [15:0] ra,
                                                  input logic [15:0] rb,
                                                  input logic [15:0] da,
                                                  input logic [15:0] db,
                                                  input logic [15:0] d,
                                                  input logic last);
    ljpes_pkg::in_word_t w;
    w.radius_a = ra;
    w.radius_b = rb;
    w.depth_a  = da;
    w.depth_b  = db;
    w.distance = d;
    w.last_pair = last;
    return w;
  endfunction

  function automatic logic [15:0] edge_value();
    case ($urandom_range(0, 2))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return $urandom_range(0, 16'hFFFF);
    endcase
  endfunction

  // Random pair: mostly physical geometry near the well, some noise and extremes.
  function automatic ljpes_pkg::in_word_t random_pair(input logic [15:0] cut);
    ljpes_pkg::in_word_t w;
    int kind;
    logic [31:0] rsum;
    kind = $urandom_range(0, 19);
    w.radius_a = $urandom_range(16'h0080, 16'h0300);
    w.radius_b = $urandom_range(16'h0080, 16'h0300);
    w.depth_a  = $urandom_range(0, 16'hFFFF);
    w.depth_b  = $urandom_range(0, 16'hFFFF);
    rsum = w.radius_a + w.radius_b;
    w.distance = (rsum * $urandom_range(205, 768)) >> 8;
    if (kind < 3) begin
      w.radius_a = $urandom_range(0, 16'hFFFF);
      w.radius_b = $urandom_range(0, 16'hFFFF);
      w.distance = $urandom_range(0, 16'hFFFF);
    end else if (kind < 6) begin
      w.radius_a = edge_value();
      w.radius_b = edge_value();
      w.depth_a  = edge_value();
      w.depth_b  = edge_value();
      w.distance = edge_value();
    end else if (kind == 6 && cut != 0) begin
      w.distance = cut - $urandom_range(0, 1);
    end
    w.last_pair = ($urandom_range(0, 7) == 0);
    return w;
  endfunction

  task automatic random_phase(input int count, input logic [15:0] cut);
    int burst;
    int sent;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        send_pair(random_pair(cut));
        sent++;
      end
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 12));
    end
    // Close the open set so its total is checked in this phase.
    send_pair(pair_of(16'h0180, 16'h0180, 16'h1000, 16'h1000, 16'h0380, 1'b1));
  endtask

  initial begin
    rst        = 1'b1;
    cycles     = 0;
    stall_mode = 0;
    cfg_valid  <= 1'b0;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    in_data    <= '0;
    out_ready  <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed pairs with no cutoff.
    send_pair(pair_of(16'h0180, 16'h0180, 16'h1000, 16'h1000, 16'h0000, 1'b1));
    send_pair(pair_of(16'h0180, 16'h0180, 16'h0000, 16'h1000, 16'h0000, 1'b1));
    send_pair(pair_of(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
    send_pair(pair_of(16'h0800, 16'h0800, 16'h1000, 16'h1000, 16'h0100, 1'b1));
    send_pair(pair_of(16'h0800, 16'h07FF, 16'hFFFF, 16'hFFFF, 16'h0100, 1'b1));
    send_pair(pair_of(16'h0180, 16'h0180, 16'h1000, 16'h1000, 16'h0300, 1'b0));
    send_pair(pair_of(16'h0180, 16'h0180, 16'h0000, 16'h0000, 16'h0300, 1'b0));
    send_pair(pair_of(16'h0180, 16'h0180, 16'h1000, 16'h2000, 16'h0600, 1'b1));
    send_pair(pair_of(16'h0000, 16'h0000, 16'h1000, 16'h1000, 16'h0100, 1'b1));
    send_pair(pair_of(16'h0180, 16'h0180, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
    send_pair(pair_of(16'h0800, 16'h07FF, 16'hFFFF, 16'hFFFF, 16'h0100, 1'b0));
    send_pair(pair_of(16'h0800, 16'h07FF, 16'hFFFF, 16'hFFFF, 16'h0100, 1'b0));
    send_pair(pair_of(16'h0800, 16'h07FF, 16'hFFFF, 16'hFFFF, 16'h0100, 1'b1));
    send_pair(pair_of(16'h0180, 16'h0180, 16'h1000, 16'h1000, 16'h0300, 1'b1));

    random_phase(400, 16'h0000);

    // Largest cutoff, with pairs at and just below it.
    set_cutoff(16'hFFFF);
    send_pair(pair_of(16'h0180, 16'h0180, 16'h1000, 16'h1000, 16'hFFFF, 1'b0));
    send_pair(pair_of(16'h0180, 16'h0180, 16'h1000, 16'h1000, 16'hFFFE, 1'b1));
    random_phase(250, 16'hFFFF);

    // Smallest nonzero cutoff: only zero distances get through.
    set_cutoff(16'h0001);
    send_pair(pair_of(16'h0180, 16'h0180, 16'h1000, 16'h1000, 16'h0000, 1'b0));
    send_pair(pair_of(16'h0180, 16'h0180, 16'h1000, 16'h1000, 16'h0001, 1'b1));
    random_phase(150, 16'h0001);

    set_cutoff(16'h0400);
    random_phase(250, 16'h0400);
    // The sender holds off until every total has come back.
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    random_phase(100, 16'h0400);

    set_cutoff($urandom_range(16'h0200, 16'h0A00));
    random_phase(200, 16'h0600);

    // Back to no cutoff.
    set_cutoff(16'h0000);
    random_phase(50, 16'h0000);

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_lennard_jones_pair_energy_sum: PASS");
    end else begin
      $display("tb_lennard_jones_pair_energy_sum: FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/ljpes_pkg.sv
hdl/ljpes_front.sv
hdl/ljpes_queue.sv
hdl/ljpes_back.sv
hdl/lennard_jones_pair_energy_sum.sv
sim/lennard_jones_pair_energy_sum_checker.sv
sim/tb_lennard_jones_pair_energy_sum.sv
